// File: rtl/core/text_field_to_utf8_transcoder_defines.svh
// Assertion macros for the text field to UTF-8 transcoder.
// Used by the top level; expects clk and rst in scope.
`ifndef TEXT_FIELD_TO_UTF8_TRANSCODER_DEFINES_SVH
`define TEXT_FIELD_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication
`define TFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tfu_pkg.sv
// Types, constants and UTF-8 helpers for the text field transcoder.
// No dependencies; used by tfu_front, tfu_fifo, tfu_back and the top level.
package tfu_pkg;

  typedef enum logic [1:0] {
    ENC_LATIN1    = 2'd0,
    ENC_UTF16_BOM = 2'd1,
    ENC_UTF16_BE  = 2'd2,
    ENC_UTF8      = 2'd3
  } enc_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [7:0]  BOM_FF         = 8'hFF;
  localparam logic [7:0]  BOM_FE         = 8'hFE;
  localparam logic [5:0]  HIGH_SUR_TAG   = 6'b110110;
  localparam logic [5:0]  LOW_SUR_TAG    = 6'b110111;

  // up to two code points per request, or a single raw byte in cp0
  typedef struct packed {
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic [1:0]  ncp;
    logic        raw;
    logic        last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic nonempty;
    job_t job;
  } q_rd_t;

  // encoded length less one
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    if (cp[20:7] == '0) begin
      return 2'd0;
    end else if (cp[20:11] == '0) begin
      return 2'd1;
    end else if (cp[20:16] == '0) begin
      return 2'd2;
    end else begin
      return 2'd3;
    end
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [1:0] lm1;
    logic [7:0] b;
    lm1 = utf8_len_m1(cp);
    b = 8'h00;
    unique case (lm1)
      2'd0: b = cp[7:0];
      2'd1: begin
        unique case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/tfu_in_if.sv
// Input channel: one raw byte of a text field with its end mark.
// No dependencies.
interface tfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_field;

  modport source (output valid, output in_byte, output end_of_field, input ready);
  modport sink (input valid, input in_byte, input end_of_field, output ready);
endinterface

// File: rtl/core/tfu_out_if.sv
// Output channel: one UTF-8 byte, data flag and field end flag.
// No dependencies.
interface tfu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                output ready);
endinterface

// File: rtl/core/tfu_front.sv
// Front end: accepts bytes, pairs UTF-16 units, tracks field state and
// issues code point requests. Depends on tfu_pkg and tfu_in_if.
module tfu_front
  import tfu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  tfu_in_if.sink       din,
  input  logic         q_full,
  output q_wr_t        q_wr
);

  enc_t        enc;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic        field_start, field_start_next;
  logic [9:0]  pending_high, pending_high_next;
  logic        pending_high_valid, pending_high_valid_next;
  logic        big_endian_order, big_endian_order_next;
  logic        stopped, stopped_next;

  logic        accept;
  logic        utf16, mark_now, be, is_low, is_high;
  logic        pre, main, eoff, raw;
  logic [15:0] unit;
  logic [20:0] main_cp;
  job_t        job;

  assign din.ready = !q_full;
  assign accept    = din.valid && !q_full;

  always_comb begin
    held_byte_next          = held_byte;
    held_valid_next         = held_valid;
    field_start_next        = field_start;
    pending_high_next       = pending_high;
    pending_high_valid_next = pending_high_valid;
    big_endian_order_next   = big_endian_order;
    stopped_next            = stopped;
    pre     = 1'b0;
    main    = 1'b0;
    raw     = 1'b0;
    main_cp = '0;
    utf16    = (enc == ENC_UTF16_BOM) || (enc == ENC_UTF16_BE);
    mark_now = (enc == ENC_UTF16_BOM) && field_start;
    be       = (enc == ENC_UTF16_BE) || (!mark_now && big_endian_order);
    unit     = be ? {held_byte, din.in_byte} : {din.in_byte, held_byte};
    is_low   = unit[15:10] == LOW_SUR_TAG;
    is_high  = unit[15:10] == HIGH_SUR_TAG;
    if (!stopped) begin
      if (utf16) begin
        if (!held_valid) begin
          held_byte_next  = din.in_byte;
          held_valid_next = 1'b1;
        end else begin
          held_byte_next  = '0;
          held_valid_next = 1'b0;
          if (mark_now) begin
            field_start_next = 1'b0;
          end
          if (mark_now && held_byte == BOM_FF && din.in_byte == BOM_FE) begin
            big_endian_order_next = 1'b0;
          end else if (mark_now && held_byte == BOM_FE && din.in_byte == BOM_FF) begin
            big_endian_order_next = 1'b1;
          end else begin
            if (mark_now) begin
              big_endian_order_next = 1'b0;
            end
            if (pending_high_valid) begin
              pending_high_valid_next = 1'b0;
              pending_high_next       = '0;
              if (is_low) begin
                main    = 1'b1;
                main_cp = CP_SUPP_BASE + {1'b0, pending_high, unit[9:0]};
              end else begin
                pre = 1'b1;
              end
            end
            if (!(pending_high_valid && is_low)) begin
              if (unit == '0) begin
                stopped_next = 1'b1;
              end else if (is_high) begin
                pending_high_next       = unit[9:0];
                pending_high_valid_next = 1'b1;
              end else if (is_low) begin
                main    = 1'b1;
                main_cp = CP_REPLACEMENT;
              end else begin
                main    = 1'b1;
                main_cp = {5'b0, unit};
              end
            end
          end
        end
      end else if (din.in_byte == '0) begin
        stopped_next = 1'b1;
      end else begin
        main    = 1'b1;
        main_cp = {13'b0, din.in_byte};
        raw     = (enc == ENC_UTF8);
      end
    end
    eoff = din.end_of_field && utf16 && !stopped_next && pending_high_valid_next;

    job.cp0  = pre ? CP_REPLACEMENT : (main ? main_cp : CP_REPLACEMENT);
    job.cp1  = (pre && main) ? main_cp : CP_REPLACEMENT;
    job.ncp  = {1'b0, pre} + {1'b0, main} + {1'b0, eoff};
    job.raw  = raw;
    job.last = din.end_of_field;

    if (din.end_of_field) begin
      held_byte_next          = '0;
      held_valid_next         = 1'b0;
      field_start_next        = 1'b1;
      pending_high_next       = '0;
      pending_high_valid_next = 1'b0;
      big_endian_order_next   = 1'b0;
      stopped_next            = 1'b0;
    end
  end

  assign q_wr.push = accept && ((job.ncp != 2'd0) || din.end_of_field);
  assign q_wr.job  = job;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      held_byte          <= '0;
      held_valid         <= 1'b0;
      field_start        <= 1'b1;
      pending_high       <= '0;
      pending_high_valid <= 1'b0;
      big_endian_order   <= 1'b0;
      stopped            <= 1'b0;
    end else if (accept) begin
      held_byte          <= held_byte_next;
      held_valid         <= held_valid_next;
      field_start        <= field_start_next;
      pending_high       <= pending_high_next;
      pending_high_valid <= pending_high_valid_next;
      big_endian_order   <= big_endian_order_next;
      stopped            <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc <= ENC_LATIN1;
    end else if (cfg_we) begin
      enc <= enc_t'(cfg_wdata);
    end
  end

endmodule

// File: rtl/core/tfu_fifo.sv
// Request queue between front and back end.
// Depends on tfu_pkg.
module tfu_fifo
  import tfu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t q_rd
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full          = count == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH);
  assign q_rd.nonempty = count != '0;
  assign q_rd.job      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (q_wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (!q_wr.push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/tfu_back.sv
// Back end: serialises queued code points into UTF-8 bytes, one per cycle while
// the output is not stalled, through an output register. Depends on tfu_pkg and tfu_out_if.
module tfu_back
  import tfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_rd_t    q_rd,
  output logic     pop,
  tfu_out_if.source dout
);

  logic        sel;
  logic [1:0]  idx;
  logic        ob_valid;
  logic [7:0]  ob_byte;
  logic        ob_data;
  logic        ob_last;

  logic        load, emit, marker, cp_done, job_done;
  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic [7:0]  cur_byte;

  assign load     = !ob_valid || dout.ready;
  assign emit     = load && q_rd.nonempty;
  assign marker   = q_rd.job.ncp == 2'd0;
  assign cur_cp   = sel ? q_rd.job.cp1 : q_rd.job.cp0;
  assign len_m1   = q_rd.job.raw ? 2'd0 : utf8_len_m1(cur_cp);
  assign cur_byte = q_rd.job.raw ? q_rd.job.cp0[7:0] : utf8_byte(cur_cp, idx);
  assign cp_done  = idx == len_m1;
  assign job_done = marker || (cp_done && ({1'b0, sel} == q_rd.job.ncp - 2'd1));
  assign pop      = emit && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      idx <= '0;
    end else if (emit) begin
      if (job_done) begin
        sel <= 1'b0;
        idx <= '0;
      end else if (cp_done) begin
        sel <= 1'b1;
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (load) begin
      ob_valid <= q_rd.nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_byte <= marker ? 8'h00 : cur_byte;
      ob_data <= !marker;
      ob_last <= q_rd.job.last && job_done;
    end
  end

  assign dout.valid     = ob_valid;
  assign dout.out_byte  = ob_byte;
  assign dout.out_valid = ob_data;
  assign dout.out_last  = ob_last;

endmodule

// File: rtl/core/text_field_to_utf8_transcoder.sv
// Text field to UTF-8 transcoder, top level.
// Path: an accepted item is written to the request queue, then serialised into the back-end output register.
// Throughput: one input byte per cycle while the four-entry request queue has room;
// output one UTF-8 byte per cycle while the output is not stalled, set by the single back-end serialiser.
// Reset: synchronous, clears queue, output register, field state; encoding to Latin-1.
// Depends on tfu_pkg, tfu_in_if, tfu_out_if, tfu_front, tfu_fifo, tfu_back.
`include "text_field_to_utf8_transcoder_defines.svh"
module text_field_to_utf8_transcoder
  import tfu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  tfu_in_if.sink     din,
  tfu_out_if.source  dout
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  tfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (din),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  tfu_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  tfu_back u_back (
    .clk  (clk),
    .rst  (rst),
    .q_rd (q_rd),
    .pop  (pop),
    .dout (dout)
  );

  `TFU_ASSERT_NOW(a_pop_nonempty, pop, q_rd.nonempty, "pop from empty queue")
  `TFU_ASSERT_NOW(a_push_room, q_wr.push, !q_full, "push into full queue")
  `TFU_ASSERT_NOW(a_marker_last, dout.valid && !dout.out_valid, dout.out_last, "marker not last")
  `TFU_ASSERT_NXT(a_push_visible, q_wr.push && !q_rd.nonempty, q_rd.nonempty, "request lost")

endmodule
